>>> hw/rtl/break_edge_histogram_defines.svh
// Assertion macros for the checker file bedh_check.sv.
`ifndef BREAK_EDGE_HISTOGRAM_DEFINES_SVH
`define BREAK_EDGE_HISTOGRAM_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define BEDH_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BEDH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/bedh_pkg.sv
`default_nettype none

package bedh_pkg;

   localparam int EDGE_W  = 11;
   localparam int AGE_W   = 11;
   localparam int SLOT_W  = 5;
   localparam int CNT_W   = 32;
   localparam int TOT_W   = 48;
   localparam int NB_W    = 5;
   localparam int LIM_W   = 17;
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   localparam logic [EDGE_W-1:0]  OPEN_END       = EDGE_W'(2000);
   localparam logic [PADDR_W-1:0] CSR_NUM_BREAKS = '0;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_ADD   = 2'd1,
      REQ_READ  = 2'd2,
      REQ_CLEAR = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_AGE_RANGE  = 2'd1,
      ST_EDGE_ORDER = 2'd2,
      ST_SLOT_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD_CHK,
      S_SCAN,
      S_TOT_ADD,
      S_READ_TOT,
      S_READ_LO,
      S_READ_UP,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } edge_ctl_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr;
   } tot_ctl_type;

endpackage

`default_nettype wire

>>> hw/rtl/bedh_edge_mem.sv
`default_nettype none

module bedh_edge_mem
   import bedh_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic              clock,
   input  wire edge_ctl_type      ctl,
   input  wire logic [AW-1:0]     addr,
   input  wire logic [EDGE_W-1:0] wdata,
   output logic      [EDGE_W-1:0] rdata
);

   logic [EDGE_W-1:0] mem_ff [DEPTH];
   logic [EDGE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[addr] <= wdata;
      end
      if (ctl.rd_en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bedh_tot_mem.sv
`default_nettype none

module bedh_tot_mem
   import bedh_pkg::*;
#(
   parameter int DEPTH = 17,
   parameter int AW    = 5
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire tot_ctl_type             ctl,
   input  wire logic [AW-1:0]           addr,
   input  wire logic signed [TOT_W-1:0] wdata,
   output logic signed      [TOT_W-1:0] rdata
);

   logic signed [TOT_W-1:0] mem_ff [DEPTH];
   logic signed [TOT_W-1:0] rdata_ff;
   logic [DEPTH-1:0]        valid_ff;

   // an entry without its valid bit reads as zero; clear drops all bits at once
   always_ff @(posedge clock) begin
      if (reset || ctl.clr) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[addr] <= wdata;
      end
      if (ctl.rd_en) begin
         rdata_ff <= valid_ff[addr] ? mem_ff[addr] : '0;
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bedh_seq.sv
`default_nettype none

module bedh_seq
   import bedh_pkg::*;
#(
   parameter int MAX_EDGES = 16,
   parameter int AGE_LIMIT = 2000,
   parameter int EAW       = 4,
   parameter int IW        = 5,
   parameter int CW        = 6
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [NB_W-1:0]         num_breaks,

   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [1:0]              req_type,
   input  wire logic [SLOT_W-1:0]       req_slot,
   input  wire logic [EDGE_W-1:0]       req_edge_value,
   input  wire logic [AGE_W-1:0]        req_age,
   input  wire logic                    req_age_missing,
   input  wire logic signed [CNT_W-1:0] req_count,

   output edge_ctl_type                 edge_ctl,
   output logic [EAW-1:0]               edge_addr,
   output logic [EDGE_W-1:0]            edge_wdata,
   input  wire logic [EDGE_W-1:0]       edge_rdata,

   output tot_ctl_type                  tot_ctl,
   output logic [IW-1:0]                tot_addr,
   output logic signed [TOT_W-1:0]      tot_wdata,
   input  wire logic signed [TOT_W-1:0] tot_rdata,

   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [SLOT_W-1:0]            rsp_group,
   output logic signed [TOT_W-1:0]      rsp_total,
   output logic [EDGE_W-1:0]            rsp_group_lower,
   output logic [EDGE_W-1:0]            rsp_group_upper
);

   localparam logic signed [TOT_W-1:0] TOT_MAX = {1'b0, {(TOT_W-1){1'b1}}};
   localparam logic signed [TOT_W-1:0] TOT_MIN = {1'b1, {(TOT_W-1){1'b0}}};

   state_type state_ff, state_in;

   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [EDGE_W-1:0]       edge_ff, edge_in;
   logic [AGE_W-1:0]        age_ff, age_in;
   logic signed [CNT_W-1:0] count_ff, count_in;
   logic [CW-1:0]           ptr_ff, ptr_in;

   status_type              res_status_ff, res_status_in;
   logic [SLOT_W-1:0]       res_group_ff, res_group_in;
   logic signed [TOT_W-1:0] res_total_ff, res_total_in;
   logic [EDGE_W-1:0]       res_lo_ff, res_lo_in;
   logic [EDGE_W-1:0]       res_up_ff, res_up_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]       rsp_group_ff, rsp_group_in;
   logic signed [TOT_W-1:0] rsp_total_ff, rsp_total_in;
   logic [EDGE_W-1:0]       rsp_lo_ff, rsp_lo_in;
   logic [EDGE_W-1:0]       rsp_up_ff, rsp_up_in;

   logic [CW-1:0]           n_use;
   logic [CW-1:0]           slot_req_w;
   logic [CW-1:0]           slot_w;
   logic [CW-1:0]           ptr_next;
   logic                    age_hi_req;
   logic                    edge_hi_req;
   logic                    age_ge;
   logic signed [TOT_W:0]   sum_w;
   logic signed [TOT_W-1:0] sat_sum;

   // edges in use: zero acts as one, clamp at the table depth
   always_comb begin
      if (num_breaks == '0) begin
         n_use = CW'(1);
      end else if (CW'(num_breaks) > CW'(MAX_EDGES)) begin
         n_use = CW'(MAX_EDGES);
      end else begin
         n_use = CW'(num_breaks);
      end
   end

   assign slot_req_w  = CW'(req_slot);
   assign slot_w      = CW'(slot_ff);
   assign ptr_next    = ptr_ff + CW'(1);
   assign age_hi_req  = LIM_W'(req_age) >= LIM_W'(AGE_LIMIT);
   assign edge_hi_req = LIM_W'(req_edge_value) >= LIM_W'(AGE_LIMIT);
   assign age_ge      = age_ff >= edge_rdata;

   assign sum_w = (TOT_W+1)'(tot_rdata) + (TOT_W+1)'(count_ff);

   always_comb begin
      if (sum_w[TOT_W] != sum_w[TOT_W-1]) begin
         sat_sum = sum_w[TOT_W] ? TOT_MIN : TOT_MAX;
      end else begin
         sat_sum = sum_w[TOT_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      edge_in       = edge_ff;
      age_in        = age_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      res_status_in = res_status_ff;
      res_group_in  = res_group_ff;
      res_total_in  = res_total_ff;
      res_lo_in     = res_lo_ff;
      res_up_in     = res_up_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_group_in  = rsp_group_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_lo_in     = rsp_lo_ff;
      rsp_up_in     = rsp_up_ff;

      req_ready  = 1'b0;
      edge_ctl   = '0;
      edge_addr  = '0;
      edge_wdata = edge_ff;
      tot_ctl    = '0;
      tot_addr   = '0;
      tot_wdata  = sat_sum;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               slot_in       = req_slot;
               edge_in       = req_edge_value;
               age_in        = req_age;
               count_in      = req_count;
               res_status_in = ST_OK;
               res_group_in  = req_slot;
               res_total_in  = '0;
               res_lo_in     = '0;
               res_up_in     = '0;
               state_in      = S_RESULT;
               unique case (req_kind_type'(req_type))
                  REQ_LOAD: begin
                     priority if (slot_req_w >= n_use) begin
                        res_status_in = ST_SLOT_RANGE;
                     end else if (edge_hi_req) begin
                        res_status_in = ST_EDGE_ORDER;
                     end else if (req_slot == '0) begin
                        edge_ctl.wr_en = 1'b1;
                        edge_wdata     = req_edge_value;
                     end else begin
                        // check against the edge below before writing
                        edge_ctl.rd_en = 1'b1;
                        edge_addr      = EAW'(slot_req_w - CW'(1));
                        state_in       = S_LOAD_CHK;
                     end
                  end
                  REQ_ADD: begin
                     res_group_in = '0;
                     priority if (!req_age_missing && age_hi_req) begin
                        res_status_in = ST_AGE_RANGE;
                     end else if (req_age_missing) begin
                        tot_ctl.rd_en = 1'b1;
                        tot_addr      = IW'(n_use);
                        ptr_in        = n_use;
                        state_in      = S_TOT_ADD;
                     end else begin
                        edge_ctl.rd_en = 1'b1;
                        ptr_in         = '0;
                        state_in       = S_SCAN;
                     end
                  end
                  REQ_READ: begin
                     priority if (slot_req_w > n_use) begin
                        res_status_in = ST_SLOT_RANGE;
                     end else if (slot_req_w == n_use) begin
                        tot_ctl.rd_en = 1'b1;
                        tot_addr      = IW'(slot_req_w);
                        state_in      = S_READ_TOT;
                     end else begin
                        edge_ctl.rd_en = 1'b1;
                        edge_addr      = EAW'(slot_req_w);
                        tot_ctl.rd_en  = 1'b1;
                        tot_addr       = IW'(slot_req_w);
                        state_in       = S_READ_LO;
                     end
                  end
                  REQ_CLEAR: begin
                     res_group_in = '0;
                     tot_ctl.clr  = 1'b1;
                  end
               endcase
            end
         end

         S_LOAD_CHK: begin
            state_in = S_RESULT;
            if (edge_ff <= edge_rdata) begin
               res_status_in = ST_EDGE_ORDER;
            end else begin
               edge_ctl.wr_en = 1'b1;
               edge_addr      = EAW'(slot_w);
            end
         end

         // edge_rdata holds the edge at ptr_ff
         S_SCAN: begin
            priority if (ptr_ff == '0 && !age_ge) begin
               tot_ctl.rd_en = 1'b1;
               tot_addr      = IW'(n_use);
               ptr_in        = n_use;
               state_in      = S_TOT_ADD;
            end else if (!age_ge) begin
               tot_ctl.rd_en = 1'b1;
               tot_addr      = IW'(ptr_ff - CW'(1));
               ptr_in        = ptr_ff - CW'(1);
               state_in      = S_TOT_ADD;
            end else if (ptr_next < n_use) begin
               edge_ctl.rd_en = 1'b1;
               edge_addr      = EAW'(ptr_next);
               ptr_in         = ptr_next;
            end else begin
               tot_ctl.rd_en = 1'b1;
               tot_addr      = IW'(ptr_ff);
               state_in      = S_TOT_ADD;
            end
         end

         S_TOT_ADD: begin
            tot_ctl.wr_en = 1'b1;
            tot_addr      = IW'(ptr_ff);
            res_group_in  = SLOT_W'(ptr_ff);
            res_total_in  = sat_sum;
            state_in      = S_RESULT;
         end

         S_READ_TOT: begin
            res_total_in = tot_rdata;
            state_in     = S_RESULT;
         end

         S_READ_LO: begin
            res_total_in = tot_rdata;
            res_lo_in    = edge_rdata;
            if (slot_w + CW'(1) < n_use) begin
               edge_ctl.rd_en = 1'b1;
               edge_addr      = EAW'(slot_w + CW'(1));
               state_in       = S_READ_UP;
            end else begin
               res_up_in = OPEN_END;
               state_in  = S_RESULT;
            end
         end

         S_READ_UP: begin
            res_up_in = edge_rdata;
            state_in  = S_RESULT;
         end

         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_group_in  = res_group_ff;
               rsp_total_in  = res_total_ff;
               rsp_lo_in     = res_lo_ff;
               rsp_up_in     = res_up_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      edge_ff       <= edge_in;
      age_ff        <= age_in;
      count_ff      <= count_in;
      ptr_ff        <= ptr_in;
      res_status_ff <= res_status_in;
      res_group_ff  <= res_group_in;
      res_total_ff  <= res_total_in;
      res_lo_ff     <= res_lo_in;
      res_up_ff     <= res_up_in;
      rsp_status_ff <= rsp_status_in;
      rsp_group_ff  <= rsp_group_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_lo_ff     <= rsp_lo_in;
      rsp_up_ff     <= rsp_up_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_group       = rsp_group_ff;
   assign rsp_total       = rsp_total_ff;
   assign rsp_group_lower = rsp_lo_ff;
   assign rsp_group_upper = rsp_up_ff;

endmodule

`default_nettype wire

>>> hw/rtl/break_edge_histogram.sv
// Channel    Direction  Handshake            Carries
// request    in         req_valid/req_ready  type, slot, edge, age, missing flag, count
// response   out        rsp_valid/rsp_ready  status, group, total, group bounds
// csr        in/out     psel/penable/pready  num_breaks at byte address 0
//
// One request at a time. An add with a missing age goes straight to its total; an add with
// an age in range scans the edges from edge 0 up to the first edge above the age or the last
// edge in use, one per cycle through the single read port of the edge memory.
// A new request is taken while the previous response waits on rsp_ready.
// Reset is synchronous; totals read as zero after reset, edges are undefined.
`default_nettype none

module break_edge_histogram
   import bedh_pkg::*;
#(
   parameter int MAX_EDGES = 16,
   parameter int AGE_LIMIT = 2000
) (
   input  wire logic                    clock,
   input  wire logic                    reset,

   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [PADDR_W-1:0]      paddr,
   input  wire logic [PDATA_W-1:0]      pwdata,
   output logic      [PDATA_W-1:0]      prdata,
   output logic                         pready,

   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [1:0]              req_type,
   input  wire logic [SLOT_W-1:0]       req_slot,
   input  wire logic [EDGE_W-1:0]       req_edge_value,
   input  wire logic [AGE_W-1:0]        req_age,
   input  wire logic                    req_age_missing,
   input  wire logic signed [CNT_W-1:0] req_count,

   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [SLOT_W-1:0]            rsp_group,
   output logic signed [TOT_W-1:0]      rsp_total,
   output logic [EDGE_W-1:0]            rsp_group_lower,
   output logic [EDGE_W-1:0]            rsp_group_upper
);

   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int IW  = $clog2(MAX_EDGES + 1);
   localparam int CW  = (IW + 1 > 6) ? IW + 1 : 6;

   logic [NB_W-1:0] num_breaks_ff, num_breaks_in;
   logic            csr_wr;

   edge_ctl_type            edge_ctl;
   logic [EAW-1:0]          edge_addr;
   logic [EDGE_W-1:0]       edge_wdata;
   logic [EDGE_W-1:0]       edge_rdata;
   tot_ctl_type             tot_ctl;
   logic [IW-1:0]           tot_addr;
   logic signed [TOT_W-1:0] tot_wdata;
   logic signed [TOT_W-1:0] tot_rdata;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      num_breaks_in = num_breaks_ff;
      if (csr_wr && paddr == CSR_NUM_BREAKS) begin
         num_breaks_in = pwdata[NB_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_breaks_ff <= NB_W'(1);
      end else begin
         num_breaks_ff <= num_breaks_in;
      end
   end

   assign prdata = (paddr == CSR_NUM_BREAKS) ? PDATA_W'(num_breaks_ff) : '0;

   bedh_seq #(
      .MAX_EDGES (MAX_EDGES),
      .AGE_LIMIT (AGE_LIMIT),
      .EAW       (EAW),
      .IW        (IW),
      .CW        (CW)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .num_breaks      (num_breaks_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_slot        (req_slot),
      .req_edge_value  (req_edge_value),
      .req_age         (req_age),
      .req_age_missing (req_age_missing),
      .req_count       (req_count),
      .edge_ctl        (edge_ctl),
      .edge_addr       (edge_addr),
      .edge_wdata      (edge_wdata),
      .edge_rdata      (edge_rdata),
      .tot_ctl         (tot_ctl),
      .tot_addr        (tot_addr),
      .tot_wdata       (tot_wdata),
      .tot_rdata       (tot_rdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_group       (rsp_group),
      .rsp_total       (rsp_total),
      .rsp_group_lower (rsp_group_lower),
      .rsp_group_upper (rsp_group_upper)
   );

   bedh_edge_mem #(
      .DEPTH (MAX_EDGES),
      .AW    (EAW)
   ) u_edge_mem (
      .clock (clock),
      .ctl   (edge_ctl),
      .addr  (edge_addr),
      .wdata (edge_wdata),
      .rdata (edge_rdata)
   );

   bedh_tot_mem #(
      .DEPTH (MAX_EDGES + 1),
      .AW    (IW)
   ) u_tot_mem (
      .clock (clock),
      .reset (reset),
      .ctl   (tot_ctl),
      .addr  (tot_addr),
      .wdata (tot_wdata),
      .rdata (tot_rdata)
   );

endmodule

`default_nettype wire

>>> hw/rtl/bedh_check.sv
`default_nettype none
`include "break_edge_histogram_defines.svh"

module bedh_check
   import bedh_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic [1:0]              rsp_status,
   input wire logic [SLOT_W-1:0]       rsp_group,
   input wire logic signed [TOT_W-1:0] rsp_total,
   input wire logic [EDGE_W-1:0]       rsp_group_lower,
   input wire logic [EDGE_W-1:0]       rsp_group_upper
);

   // one request in flight: ready drops right after a request is taken
   `BEDH_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while busy")

   `BEDH_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_group) && $stable(rsp_total), "stalled response changed")

   // error responses carry no total and no bounds
   `BEDH_ASSERT_NOW(a_err_zero, rsp_valid && rsp_status != ST_OK, rsp_total == '0 && rsp_group_lower == '0 && rsp_group_upper == '0, "error response with data")

   `BEDH_ASSERT_NOW(a_age_err_group, rsp_valid && rsp_status == ST_AGE_RANGE, rsp_group == '0, "age error with nonzero group")

endmodule

bind break_edge_histogram bedh_check u_check (.*);

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench
   import bedh_pkg::*;
();

   localparam int EDGE_SLOTS = 16;
   localparam int AGE_CEIL   = 2000;
   localparam int QUIET_MAX  = 3000;
   localparam int SHOW_MAX   = 40;
   localparam int BURST_LEN  = 50;
   localparam int PHASE_LEN  = 90;
   localparam longint TOTAL_HI = 64'sd140737488355327;
   localparam longint TOTAL_LO = -TOTAL_HI - 1;

   typedef struct {
      req_kind_type            kind;
      logic [SLOT_W-1:0]       slot;
      logic [EDGE_W-1:0]       edge_v;
      logic [AGE_W-1:0]        age;
      logic                    missing;
      logic signed [CNT_W-1:0] weight;
   } histo_req_type;

   typedef struct {
      status_type              status;
      logic [SLOT_W-1:0]       group;
      logic signed [TOT_W-1:0] total;
      logic [EDGE_W-1:0]       lower;
      logic [EDGE_W-1:0]       upper;
   } histo_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               psel    = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite  = 1'b0;
   logic [PADDR_W-1:0] paddr   = '0;
   logic [PDATA_W-1:0] pwdata  = '0;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   logic                    req_valid       = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_type        = REQ_LOAD;
   logic [SLOT_W-1:0]       req_slot        = '0;
   logic [EDGE_W-1:0]       req_edge_value  = '0;
   logic [AGE_W-1:0]        req_age         = '0;
   logic                    req_age_missing = 1'b0;
   logic signed [CNT_W-1:0] req_count       = '0;

   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [1:0]              rsp_status;
   logic [SLOT_W-1:0]       rsp_group;
   logic signed [TOT_W-1:0] rsp_total;
   logic [EDGE_W-1:0]       rsp_group_lower;
   logic [EDGE_W-1:0]       rsp_group_upper;

   // histogram state as the block should hold it
   logic [NB_W-1:0]         breaks_reg = NB_W'(1);
   logic [EDGE_W-1:0]       edge_mem [EDGE_SLOTS];
   logic signed [TOT_W-1:0] group_sum [EDGE_SLOTS+1];

   histo_req_type histo_requests [$];
   histo_rsp_type histo_answers [$];
   histo_req_type in_flight;

   bit steady = 1'b0;
   int fail_count = 0;
   int quiet = 0;
   int clamp_hits = 0;
   int settings_used = 0;
   int kind_seen [4] = '{default: 0};
   int status_seen [4] = '{default: 0};

   break_edge_histogram DUT (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_slot        (req_slot),
      .req_edge_value  (req_edge_value),
      .req_age         (req_age),
      .req_age_missing (req_age_missing),
      .req_count       (req_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_group       (rsp_group),
      .rsp_total       (rsp_total),
      .rsp_group_lower (rsp_group_lower),
      .rsp_group_upper (rsp_group_upper)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int breaks_in_use();
      if (breaks_reg == 0) return 1;
      if (breaks_reg > EDGE_SLOTS) return EDGE_SLOTS;
      return int'(breaks_reg);
   endfunction

   // applies one request to the histogram state and returns its response
   function automatic histo_rsp_type tally_request(histo_req_type r);
      histo_rsp_type o;
      int n, g, s;
      longint sum;
      n = breaks_in_use();
      s = int'(r.slot);
      o.status = ST_OK;
      o.group  = '0;
      o.total  = '0;
      o.lower  = '0;
      o.upper  = '0;
      case (r.kind)
         REQ_LOAD: begin
            o.group = r.slot;
            if (s >= n)
               o.status = ST_SLOT_RANGE;
            else if (r.edge_v >= AGE_CEIL || (s > 0 && r.edge_v <= edge_mem[s-1]))
               o.status = ST_EDGE_ORDER;
            else
               edge_mem[s] = r.edge_v;
         end
         REQ_ADD: begin
            if (!r.missing && r.age >= AGE_CEIL) begin
               o.status = ST_AGE_RANGE;
            end else begin
               if (r.missing || r.age < edge_mem[0]) begin
                  g = n;
               end else begin
                  // step up while the next edge is not above the age
                  g = 0;
                  while (g + 1 < n && r.age >= edge_mem[g+1]) g++;
               end
               sum = longint'(group_sum[g]) + longint'(r.weight);
               if (sum > TOTAL_HI) begin
                  sum = TOTAL_HI;
                  clamp_hits++;
               end else if (sum < TOTAL_LO) begin
                  sum = TOTAL_LO;
                  clamp_hits++;
               end
               group_sum[g] = TOT_W'(sum);
               o.group = SLOT_W'(g);
               o.total = group_sum[g];
            end
         end
         REQ_READ: begin
            o.group = r.slot;
            if (s > n) begin
               o.status = ST_SLOT_RANGE;
            end else begin
               o.total = group_sum[s];
               if (s < n) begin
                  o.lower = edge_mem[s];
                  o.upper = (s + 1 < n) ? edge_mem[s+1] : OPEN_END;
               end
            end
         end
         default: begin
            foreach (group_sum[i]) group_sum[i] = '0;
         end
      endcase
      kind_seen[r.kind]++;
      status_seen[o.status]++;
      return o;
   endfunction

   function automatic histo_req_type make_request();
      histo_req_type r;
      int n, pick, a, base;
      n = breaks_in_use();
      r.kind    = REQ_ADD;
      r.slot    = SLOT_W'($urandom);
      r.edge_v  = EDGE_W'($urandom);
      r.age     = AGE_W'($urandom);
      r.missing = 1'($urandom_range(0, 1));
      r.weight  = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         r.kind = REQ_LOAD;
         if ($urandom_range(0, 4) != 0) r.slot = SLOT_W'($urandom_range(0, n - 1));
         // mostly edges just above the previous one so loads land
         if ($urandom_range(0, 9) < 6) begin
            base = (r.slot > 0 && r.slot < EDGE_SLOTS) ? int'(edge_mem[r.slot-1]) + 1 : 0;
            base = base + int'($urandom_range(0, 150));
            r.edge_v = EDGE_W'((base > 2047) ? 2047 : base);
         end
      end else if (pick < 75) begin
         r.missing = ($urandom_range(0, 9) == 0);
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            a = int'(edge_mem[$urandom_range(0, n - 1)]) + int'($urandom_range(0, 4)) - 2;
            r.age = AGE_W'((a < 0) ? 0 : a);
         end else if (pick < 9) begin
            r.age = AGE_W'($urandom_range(0, AGE_CEIL - 1));
         end
         pick = $urandom_range(0, 9);
         if (pick >= 4 && pick < 7) begin
            r.weight = int'($urandom_range(0, 131072)) - 65536;
         end else if (pick >= 7) begin
            case ($urandom_range(0, 3))
               0:       r.weight = 32'sh7FFF_FFFF;
               1:       r.weight = 32'sh8000_0000;
               2:       r.weight = '0;
               default: r.weight = -1;
            endcase
         end
      end else if (pick < 97) begin
         r.kind = REQ_READ;
         if ($urandom_range(0, 19) != 0) r.slot = SLOT_W'($urandom_range(0, n));
      end else begin
         r.kind = REQ_CLEAR;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (fail_count < SHOW_MAX) $display("[%0t] mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic post(req_kind_type k, int s, int ev, int ag, bit miss, int w);
      histo_req_type r;
      r.kind    = k;
      r.slot    = SLOT_W'(s);
      r.edge_v  = EDGE_W'(ev);
      r.age     = AGE_W'(ag);
      r.missing = miss;
      r.weight  = CNT_W'(w);
      histo_requests.push_back(r);
   endtask

   task automatic settle();
      while (histo_requests.size() != 0 || req_valid || histo_answers.size() != 0)
         @(posedge clock);
   endtask

   // write num_breaks, then read it back
   task automatic set_breaks(input logic [NB_W-1:0] v);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_NUM_BREAKS;
      pwdata  <= PDATA_W'(v);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      breaks_reg = v;
      settings_used++;
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== PDATA_W'(v))
         report_mismatch($sformatf("num_breaks reads %0d, wrote %0d", prdata, v));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   always @(posedge clock) begin : feed_req
      histo_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) histo_answers.push_back(tally_request(in_flight));
         if (!req_valid || req_ready) begin
            if (histo_requests.size() != 0 && (steady || $urandom_range(0, 99) >= 28)) begin
               nxt = histo_requests.pop_front();
               in_flight = nxt;
               req_type        <= nxt.kind;
               req_slot        <= nxt.slot;
               req_edge_value  <= nxt.edge_v;
               req_age         <= nxt.age;
               req_age_missing <= nxt.missing;
               req_count       <= nxt.weight;
               req_valid       <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_rsp
      histo_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (histo_answers.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               want = histo_answers.pop_front();
               if (rsp_status !== want.status || rsp_group !== want.group ||
                   rsp_total !== want.total || rsp_group_lower !== want.lower ||
                   rsp_group_upper !== want.upper)
                  report_mismatch($sformatf(
                     "got st %0d grp %0d tot %0d lo %0d up %0d, want %0d %0d %0d %0d %0d",
                     rsp_status, rsp_group, rsp_total, rsp_group_lower, rsp_group_upper,
                     want.status, want.group, want.total, want.lower, want.upper));
            end
         end
         rsp_ready <= steady || ($urandom_range(0, 99) >= 28);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
            quiet <= 0;
         end else if (quiet >= QUIET_MAX) begin
            $display("no progress for %0d cycles, %0d responses outstanding",
                     quiet, histo_answers.size());
            $display("testbench: FAIL");
            $finish;
         end else begin
            quiet <= quiet + 1;
         end
      end
   end

   initial begin : run
      int nb;
      int extremes [6];
      extremes = '{0, 31, 1, 16, 17, 2};
      foreach (edge_mem[i]) edge_mem[i] = '0;
      foreach (group_sum[i]) group_sum[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // one edge in use after reset; only edge 0 may be written yet
      @(negedge clock);
      post(REQ_LOAD, 3, 100, 0, 0, 0);
      post(REQ_LOAD, 0, 2000, 0, 0, 0);
      post(REQ_LOAD, 0, 5, 0, 0, 0);
      settle();
      set_breaks(NB_W'(16));
      @(negedge clock);
      for (int k = 1; k < EDGE_SLOTS; k++) post(REQ_LOAD, k, 5 + 120 * k, 0, 0, 0);

      // edges now 5, 125, 245, ... 1805
      post(REQ_LOAD, 0, 2047, 0, 0, 0);
      post(REQ_LOAD, 5, 485, 0, 0, 0);
      post(REQ_LOAD, 17, 0, 0, 0, 0);
      post(REQ_LOAD, 31, 100, 0, 0, 0);
      post(REQ_ADD, 0, 0, 0, 0, 32'h7FFF_FFFF);
      post(REQ_ADD, 0, 0, 2047, 1, 32'h8000_0000);
      post(REQ_ADD, 0, 0, 2047, 0, 5);
      post(REQ_ADD, 0, 0, 2000, 0, 5);
      post(REQ_ADD, 0, 0, 1999, 0, -1);
      post(REQ_ADD, 0, 0, 5, 0, 65536);
      post(REQ_ADD, 0, 0, 124, 0, 3);
      post(REQ_ADD, 0, 0, 125, 0, -3);
      post(REQ_READ, 15, 0, 0, 0, 0);
      post(REQ_READ, 16, 0, 0, 0, 0);
      post(REQ_READ, 0, 0, 0, 0, 0);
      post(REQ_READ, 17, 0, 0, 0, 0);
      post(REQ_READ, 31, 0, 0, 0, 0);
      // edge 3 above edge 4: binning stops at the first edge above the age
      post(REQ_LOAD, 3, 1500, 0, 0, 0);
      post(REQ_ADD, 0, 0, 600, 0, 7);
      post(REQ_READ, 2, 0, 0, 0, 0);
      post(REQ_CLEAR, 0, 0, 0, 0, 0);
      post(REQ_READ, 16, 0, 0, 0, 0);
      settle();

      // back-to-back runs of extreme counts into one group each
      set_breaks(NB_W'(1));
      @(negedge clock);
      steady = 1'b1;
      post(REQ_CLEAR, 0, 0, 0, 0, 0);
      repeat (BURST_LEN) post(REQ_ADD, 0, 0, 0, 1, 32'h7FFF_FFFF);
      post(REQ_READ, 1, 0, 0, 0, 0);
      post(REQ_CLEAR, 0, 0, 0, 0, 0);
      repeat (BURST_LEN) post(REQ_ADD, 0, 0, 1999, 0, 32'h8000_0000);
      post(REQ_READ, 0, 0, 0, 0, 0);
      post(REQ_ADD, 0, 0, 1999, 0, 32'h7FFF_FFFF);
      settle();
      @(negedge clock);
      steady = 1'b0;

      for (int p = 0; p < 13; p++) begin
         settle();
         nb = (p < 6) ? extremes[p] : int'($urandom_range(0, 31));
         set_breaks(NB_W'(nb));
         @(negedge clock);
         repeat (PHASE_LEN) histo_requests.push_back(make_request());
      end

      settle();
      repeat (40) @(posedge clock);
      if (histo_answers.size() != 0)
         report_mismatch($sformatf("%0d responses never came", histo_answers.size()));
      $display("covered %0d loads, %0d adds, %0d reads, %0d clears over %0d num_breaks writes",
               kind_seen[REQ_LOAD], kind_seen[REQ_ADD], kind_seen[REQ_READ],
               kind_seen[REQ_CLEAR], settings_used);
      $display("status ok/age/edge/slot %0d/%0d/%0d/%0d, %0d clamped totals, %0d mismatches",
               status_seen[ST_OK], status_seen[ST_AGE_RANGE], status_seen[ST_EDGE_ORDER],
               status_seen[ST_SLOT_RANGE], clamp_hits, fail_count);
      if (fail_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
